// ===== design/ulen_pkg.sv =====
`timescale 1ns / 1ps

package ulen_pkg;

    // Character codes used by the decoder
    localparam logic [7:0]  C_NUL = 8'h00;
    localparam logic [7:0]  C_LF  = 8'h0A;
    localparam logic [7:0]  C_CR  = 8'h0D;
    localparam logic [20:0] C_NEWLINE = 21'h00000A;
    localparam logic [20:0] C_NEL = 21'h000085;
    localparam logic [20:0] C_LS  = 21'h002028;
    localparam logic [20:0] C_PS  = 21'h002029;

    // Result queue depth (two results may be pushed per byte)
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = 2;

    typedef struct packed {
        logic        has_char;
        logic [20:0] code_point;
        logic        run_end;
        logic        decode_ok;
    } t_result;

    // Push request from the decoder to the result queue
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== design/ulen_if.sv =====
`timescale 1ns / 1ps

// Raw byte channel
interface ulen_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// Decoded result channel
interface ulen_char_if;
    logic        valid;
    logic        ready;
    logic        has_char;
    logic [20:0] code_point;
    logic        run_end;
    logic        decode_ok;

    modport source (output valid, output has_char, output code_point, output run_end,
                    output decode_ok, input ready);
    modport sink   (input valid, input has_char, input code_point, input run_end,
                    input decode_ok, output ready);
endinterface

// Configuration write channel (skip count)
interface ulen_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ulen_res_queue.sv =====
`timescale 1ns / 1ps

// Small result queue: up to two pushes and one pop per cycle
module ulen_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ulen_pkg::t_push   i_push,
    input  logic              i_pop,
    output ulen_pkg::t_result o_head,
    output logic              o_valid,
    output logic              o_free2
);

    ulen_pkg::t_result r_mem [ulen_pkg::RQ_DEPTH];
    logic [ulen_pkg::RQ_AW-1:0] r_wptr, n_wptr;
    logic [ulen_pkg::RQ_AW-1:0] r_rptr, n_rptr;
    logic [ulen_pkg::RQ_AW:0]   r_cnt, n_cnt;
    logic                       pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_free2 = (r_cnt <= (ulen_pkg::RQ_AW + 1)'(ulen_pkg::RQ_DEPTH - 2));

    // Pointer and fill count update
    always_comb begin
        n_wptr = r_wptr + ulen_pkg::RQ_AW'(i_push.cnt);
        n_rptr = r_rptr + ulen_pkg::RQ_AW'(pop_ok);
        n_cnt  = r_cnt + (ulen_pkg::RQ_AW + 1)'(i_push.cnt)
                       - (ulen_pkg::RQ_AW + 1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wptr + ulen_pkg::RQ_AW'(1)] <= i_push.second;
        end
    end

endmodule

// ===== design/utf8_decode_line_end_normalize_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Transfer moves                      Notes
// i_byte    in   data_byte[7:0], end_of_data         one raw stream byte
// o_char    out  has_char, code_point[20:0],         0, 1 or 2 results per byte
//                run_end, decode_ok
// i_cfg     in   data[15:0]                          skip count, ready always high
//
// One byte is taken every cycle unless the input register holds; each byte is
// decoded combinationally from the input register and its results are written
// into the result queue, then read from its head. Results leave at one per cycle
// while o_char.ready is high; a byte at stream end may push two results. The input
// register holds while the four-entry result queue lacks room for two results.
// Synchronous active-low reset clears the stream state, skip count and queue.
module utf8_decode_line_end_normalize_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ulen_byte_if.sink   i_byte,
    ulen_char_if.source o_char,
    ulen_cfg_if.sink    i_cfg
);

    // Configuration
    logic [15:0] r_skip_count;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eod;

    // Stream state
    logic        r_pend_cr, n_pend_cr;
    logic        r_halted, n_halted;
    logic        r_err, n_err;
    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_remain, n_remain;
    logic [1:0]  r_seqlen, n_seqlen;
    logic [15:0] r_skipped, n_skipped;

    logic              proc;
    logic              q_free2;
    logic              q_valid;
    ulen_pkg::t_result q_head;
    ulen_pkg::t_push   push;

    logic        ch_valid;
    logic [20:0] ch_cp;
    logic        ch_ok;
    logic        sec_ok;
    logic [20:0] cp;
    logic        bad;
    logic        bad_end;
    ulen_pkg::t_result ch_res;
    ulen_pkg::t_result fin_res;

    assign proc         = r_in_valid && q_free2;
    assign i_byte.ready = !r_in_valid || proc;
    assign i_cfg.ready  = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count <= '0;
        end else if (i_cfg.valid) begin
            r_skip_count <= i_cfg.data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eod  <= i_byte.end_of_data;
        end
    end

    // First continuation byte range check (overlong, surrogate, above max)
    always_comb begin
        sec_ok = 1'b1;
        if (r_seqlen == 2'd2) begin
            if (r_partial == 21'h0 && r_in_byte < 8'hA0) sec_ok = 1'b0;
            if (r_partial == 21'hD && r_in_byte > 8'h9F) sec_ok = 1'b0;
        end else if (r_seqlen == 2'd3) begin
            if (r_partial == 21'h0 && r_in_byte < 8'h90) sec_ok = 1'b0;
            if (r_partial == 21'h4 && r_in_byte > 8'h8F) sec_ok = 1'b0;
        end
    end

    // Byte decode
    always_comb begin
        n_pend_cr = r_pend_cr;
        n_halted  = r_halted;
        n_err     = r_err;
        n_partial = r_partial;
        n_remain  = r_remain;
        n_seqlen  = r_seqlen;
        n_skipped = r_skipped;
        ch_valid  = 1'b0;
        ch_cp     = '0;
        bad       = 1'b0;
        cp        = {r_partial[14:0], r_in_byte[5:0]};

        if (!r_halted) begin
            priority if (r_skipped < r_skip_count) begin
                n_skipped = r_skipped + 16'd1;
            end else if (r_remain != 2'd0) begin
                priority if (r_in_byte[7:6] != 2'b10) begin
                    bad = 1'b1;
                end else if (r_remain == r_seqlen && !sec_ok) begin
                    bad = 1'b1;
                end else begin
                    n_partial = cp;
                    n_remain  = r_remain - 2'd1;
                    if (r_remain == 2'd1) begin
                        ch_valid = 1'b1;
                        if (cp == ulen_pkg::C_NEL || cp == ulen_pkg::C_LS
                                || cp == ulen_pkg::C_PS) begin
                            ch_cp = ulen_pkg::C_NEWLINE;
                        end else begin
                            ch_cp     = cp;
                            n_pend_cr = 1'b0;
                        end
                    end
                end
            end else if (r_in_byte == ulen_pkg::C_NUL) begin
                n_halted = 1'b1;
            end else if (r_in_byte == ulen_pkg::C_LF) begin
                ch_valid  = !r_pend_cr;
                ch_cp     = ulen_pkg::C_NEWLINE;
                n_pend_cr = 1'b0;
            end else if (r_in_byte == ulen_pkg::C_CR) begin
                ch_valid  = 1'b1;
                ch_cp     = ulen_pkg::C_NEWLINE;
                n_pend_cr = 1'b1;
            end else if (r_in_byte < 8'h80) begin
                ch_valid  = 1'b1;
                ch_cp     = {13'd0, r_in_byte};
                n_pend_cr = 1'b0;
            end else if (r_in_byte >= 8'hC2 && r_in_byte <= 8'hDF) begin
                n_partial = {16'd0, r_in_byte[4:0]};
                n_seqlen  = 2'd1;
                n_remain  = 2'd1;
            end else if (r_in_byte >= 8'hE0 && r_in_byte <= 8'hEF) begin
                n_partial = {17'd0, r_in_byte[3:0]};
                n_seqlen  = 2'd2;
                n_remain  = 2'd2;
            end else if (r_in_byte >= 8'hF0 && r_in_byte <= 8'hF4) begin
                n_partial = {18'd0, r_in_byte[2:0]};
                n_seqlen  = 2'd3;
                n_remain  = 2'd3;
            end else begin
                bad = 1'b1;
            end
        end

        // Malformed sequence
        if (bad) begin
            n_err     = 1'b1;
            n_halted  = 1'b1;
            n_pend_cr = 1'b0;
            n_remain  = 2'd0;
        end

        ch_ok = !r_err;

        // Truncated sequence at stream end
        bad_end = r_in_eod && !n_halted && (n_remain != 2'd0);
        if (bad_end) begin
            n_err     = 1'b1;
            n_halted  = 1'b1;
            n_pend_cr = 1'b0;
            n_remain  = 2'd0;
        end

        fin_res.has_char   = n_pend_cr;
        fin_res.code_point = n_pend_cr ? ulen_pkg::C_NEWLINE : 21'd0;
        fin_res.run_end    = 1'b1;
        fin_res.decode_ok  = !n_err;

        ch_res.has_char    = 1'b1;
        ch_res.code_point  = ch_cp;
        ch_res.run_end     = 1'b0;
        ch_res.decode_ok   = ch_ok;

        // Stream end clears everything but the skip count
        if (r_in_eod) begin
            n_pend_cr = 1'b0;
            n_halted  = 1'b0;
            n_err     = 1'b0;
            n_partial = '0;
            n_remain  = '0;
            n_seqlen  = '0;
            n_skipped = '0;
        end
    end

    // Results pushed for this byte, packed in order
    always_comb begin
        push.cnt    = 2'd0;
        push.first  = ch_res;
        push.second = fin_res;
        if (proc) begin
            push.cnt = {1'b0, ch_valid} + {1'b0, r_in_eod};
            if (!ch_valid) begin
                push.first = fin_res;
            end
        end
    end

    // Stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cr <= 1'b0;
            r_halted  <= 1'b0;
            r_err     <= 1'b0;
            r_partial <= '0;
            r_remain  <= '0;
            r_seqlen  <= '0;
            r_skipped <= '0;
        end else if (proc) begin
            r_pend_cr <= n_pend_cr;
            r_halted  <= n_halted;
            r_err     <= n_err;
            r_partial <= n_partial;
            r_remain  <= n_remain;
            r_seqlen  <= n_seqlen;
            r_skipped <= n_skipped;
        end
    end

    ulen_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_char.ready),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_free2 (q_free2)
    );

    assign o_char.valid      = q_valid;
    assign o_char.has_char   = q_head.has_char;
    assign o_char.code_point = q_head.code_point;
    assign o_char.run_end    = q_head.run_end;
    assign o_char.decode_ok  = q_head.decode_ok;

    // Assertions
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_eod |=> (r_skipped == 16'd0) && !r_halted && !r_err && !r_pend_cr)
        else $error("stream state not cleared after end of data");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_free2 |-> (push.cnt == 2'd0))
        else $error("push into result queue without room");

    a_final_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && o_char.run_end && o_char.has_char
            |-> (o_char.code_point == ulen_pkg::C_NEWLINE))
        else $error("final result carries a character other than newline");

    a_held_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !q_free2 |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte lost");

endmodule
